// File: rtl/uart_rb_pkg.sv
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared types and constants for the receive ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package uart_rb_pkg;

    localparam int unsigned BUFFER_DEPTH = 4096;
    localparam int unsigned ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam logic [31:0] DEPTH_W32    = 32'(BUFFER_DEPTH);

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [3:0] line_error;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_valid;
        logic        overflow_event;
        logic [31:0] fill_count;
        logic [31:0] overflow_total;
        logic [31:0] line_error_total;
        logic [31:0] fill_high_water;
        logic [31:0] bytes_received;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_STATUS
    } t_op_kind;

    // classified operation handed from front end to back end
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] rx_byte;
        logic       has_error;
    } t_op;

    typedef enum logic {
        BK_RUN,
        BK_READ
    } t_back_state;

endpackage

`default_nettype wire

// File: rtl/uart_rb_front.sv
// ----------------------------------------------------------------------------
// uart_rb_front
// Accepts input items, decodes the command and queues the operation.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rb_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire uart_rb_pkg::t_in_item i_in_item,
    output logic                       o_op_valid,
    input  wire                        i_op_ready,
    output uart_rb_pkg::t_op           o_op
);
    import uart_rb_pkg::*;

    t_op        op_dec;
    t_op        r_q_data [2];
    logic       r_wr_idx;
    logic       r_rd_idx;
    logic [1:0] r_q_cnt;
    logic       push_q;
    logic       pop_q;

    always_comb begin
        op_dec.rx_byte   = i_in_item.rx_byte;
        op_dec.has_error = (i_in_item.line_error != 4'd0);
        unique case (i_in_item.command)
            CMD_PUSH: op_dec.kind = OP_PUSH;
            CMD_POP:  op_dec.kind = OP_POP;
            default:  op_dec.kind = OP_STATUS;
        endcase
    end

    assign o_in_ready = (r_q_cnt != 2'd2);
    assign o_op_valid = (r_q_cnt != 2'd0);
    assign o_op       = r_q_data[r_rd_idx];
    assign push_q     = i_in_valid && o_in_ready;
    assign pop_q      = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_q_cnt  <= 2'd0;
        end else begin
            if (push_q) begin
                r_wr_idx <= ~r_wr_idx;
            end
            if (pop_q) begin
                r_rd_idx <= ~r_rd_idx;
            end
            case ({push_q, pop_q})
                2'b10:   r_q_cnt <= r_q_cnt + 2'd1;
                2'b01:   r_q_cnt <= r_q_cnt - 2'd1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_q) begin
            r_q_data[r_wr_idx] <= op_dec;
        end
    end

endmodule

`default_nettype wire

// File: rtl/uart_rb_back.sv
// ----------------------------------------------------------------------------
// uart_rb_back
// Executes queued operations on the byte store, pointers and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rb_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_op_valid,
    output logic                   o_op_ready,
    input  wire uart_rb_pkg::t_op  i_op,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output uart_rb_pkg::t_out_item o_out_item
);
    import uart_rb_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [31:0] r_wp;
    logic [31:0] r_rp;
    logic [31:0] r_err_cnt;
    logic [31:0] r_ovf_cnt;
    logic [31:0] r_hwm;
    logic [31:0] r_rx_cnt;
    logic [31:0] n_wp;
    logic [31:0] n_rp;
    logic [31:0] n_err_cnt;
    logic [31:0] n_ovf_cnt;
    logic [31:0] n_hwm;
    logic [31:0] n_rx_cnt;

    logic [7:0]  r_mem [BUFFER_DEPTH];
    logic [7:0]  r_mem_q;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        out_free;
    logic        exec;
    logic        load_read;
    logic        is_push;
    logic        pop_hit;
    logic        full;
    logic [31:0] fill;
    logic [31:0] rp_eff;

    assign out_free = !r_out_valid || i_out_ready;
    assign fill     = r_wp - r_rp;
    assign full     = (fill >= DEPTH_W32);
    assign is_push  = (i_op.kind == OP_PUSH);
    assign pop_hit  = (i_op.kind == OP_POP) && (r_wp != r_rp);
    // oldest bytes dropped when the store has wrapped onto itself
    assign rp_eff   = full ? (r_wp + 32'd1 - DEPTH_W32) : r_rp;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_RUN: begin
                if (exec && pop_hit) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: n_state = BK_RUN;
            default: n_state = BK_RUN;
        endcase
    end

    always_comb begin
        exec      = 1'b0;
        load_read = 1'b0;
        unique case (r_state)
            BK_RUN:  exec      = i_op_valid && out_free;
            BK_READ: load_read = 1'b1;
            default: exec      = 1'b0;
        endcase
    end

    assign o_op_ready = exec;

    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_rx_cnt  = r_rx_cnt;
        n_ovf_cnt = r_ovf_cnt;
        n_hwm     = r_hwm;
        n_err_cnt = i_op.has_error ? r_err_cnt + 32'd1 : r_err_cnt;
        if (is_push) begin
            n_wp     = r_wp + 32'd1;
            n_rx_cnt = r_rx_cnt + 32'd1;
        end else if (pop_hit) begin
            n_rp = rp_eff + 32'd1;
            if (r_hwm < fill) begin
                n_hwm = fill;
            end
            if (full) begin
                n_ovf_cnt = r_ovf_cnt + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_wp        <= 32'd0;
            r_rp        <= 32'd0;
            r_err_cnt   <= 32'd0;
            r_ovf_cnt   <= 32'd0;
            r_hwm       <= 32'd0;
            r_rx_cnt    <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec) begin
                r_wp        <= n_wp;
                r_rp        <= n_rp;
                r_err_cnt   <= n_err_cnt;
                r_ovf_cnt   <= n_ovf_cnt;
                r_hwm       <= n_hwm;
                r_rx_cnt    <= n_rx_cnt;
                // a pop with data shows up once the store read returns
                r_out_valid <= !pop_hit;
            end else if (load_read) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out.read_data        <= 8'd0;
            r_out.read_valid       <= pop_hit;
            r_out.overflow_event   <= pop_hit && full;
            r_out.fill_count       <= n_wp - n_rp;
            r_out.overflow_total   <= n_ovf_cnt;
            r_out.line_error_total <= n_err_cnt;
            r_out.fill_high_water  <= n_hwm;
            r_out.bytes_received   <= n_rx_cnt;
        end else if (load_read) begin
            r_out.read_data <= r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && is_push) begin
            r_mem[r_wp[ADDR_W-1:0]] <= i_op.rx_byte;
        end
        if (exec && pop_hit) begin
            r_mem_q <= r_mem[rp_eff[ADDR_W-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: rtl/uart_rx_ring_buffer.sv
// ----------------------------------------------------------------------------
// uart_rx_ring_buffer
// Receive FIFO with free-running pointers, oldest-byte overwrite and counters.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result. Items enter a two-deep queue
// and the back end takes one per cycle for push, status and empty pop while
// its output is free; a pop with a byte waits on the registered read port of
// the 4096-byte store. The store needs no clearing pass after reset, so the
// block accepts items from the first cycle after reset. A push into a full
// store overwrites the oldest byte and the next pop drops the stale bytes.
`default_nettype none

module uart_rx_ring_buffer (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire uart_rb_pkg::t_in_item i_in_item,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output uart_rb_pkg::t_out_item     o_out_item
);
    import uart_rb_pkg::*;

    logic op_valid;
    logic op_ready;
    t_op  op;

    uart_rb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    uart_rb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .o_op_ready  (op_ready),
        .i_op        (op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// File: rtl/uart_rb_checker.sv
// ----------------------------------------------------------------------------
// uart_rb_checker
// Port-level checks on the receive ring buffer results.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rb_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         o_out_valid,
    input wire                         i_out_ready,
    input wire uart_rb_pkg::t_out_item o_out_item
);
    import uart_rb_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // no byte means zero data
    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.read_valid |-> o_out_item.read_data == 8'd0)
        else $error("read_data nonzero without a byte");

    // a drop only happens on a pop that returns a byte
    a_drop_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.overflow_event |-> o_out_item.read_valid)
        else $error("overflow without a returned byte");

    // after a drop and pop the fill sits two below the depth
    a_drop_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.overflow_event
            |-> o_out_item.fill_count == DEPTH_W32 - 32'd2)
        else $error("fill after overflow drop is wrong");

endmodule

bind uart_rx_ring_buffer uart_rb_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
